>>> hw/rtl/geometry_spec_parser_core_macros.svh
// assertion helpers for the geometry string parser
`ifndef GEOMETRY_SPEC_PARSER_CORE_MACROS_SVH
`define GEOMETRY_SPEC_PARSER_CORE_MACROS_SVH

// same-cycle implication, checked on clk and off during rst
`define GSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk and off during rst
`define GSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared widths, character codes and mask bit positions for the geometry
// string parser.
// ----------------------------------------------------------------------------
`default_nettype none

package gsp_pkg;

  localparam int unsigned GSP_VALUE_MAX = 32'd65535;

  localparam int CHAR_W   = 8;
  localparam int MASK_W   = 6;
  localparam int OFFS_W   = 17;
  localparam int WIDTH_W  = 16;
  localparam int HEIGHT_W = 17;

  localparam logic [CHAR_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CHAR_W-1:0] CH_EQ      = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UPPER_X = 8'h58;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;

  // bit positions in found_mask
  localparam int MB_X     = 0;
  localparam int MB_Y     = 1;
  localparam int MB_W     = 2;
  localparam int MB_H     = 3;
  localparam int MB_X_NEG = 4;
  localparam int MB_Y_NEG = 5;

endpackage

`default_nettype wire

>>> hw/rtl/gsp_char_if.sv
// ----------------------------------------------------------------------------
// gsp_char_if
// Valid/ready channel carrying one byte of a geometry string.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsp_char_if
  import gsp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/gsp_result_if.sv
// ----------------------------------------------------------------------------
// gsp_result_if
// Valid/ready channel carrying one parsed geometry result.
// ----------------------------------------------------------------------------
`default_nettype none

interface gsp_result_if
  import gsp_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [MASK_W-1:0]          found_mask;
  logic signed [OFFS_W-1:0]   x_offset;
  logic signed [OFFS_W-1:0]   y_offset;
  logic [WIDTH_W-1:0]         width_value;
  logic signed [HEIGHT_W-1:0] height_value;

  modport source (output valid, output found_mask, output x_offset, output y_offset,
                  output width_value, output height_value, input ready);
  modport sink   (input valid, input found_mask, input x_offset, input y_offset,
                  input width_value, input height_value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/geometry_spec_parser_core.sv
// ----------------------------------------------------------------------------
// geometry_spec_parser_core
// Parses a window geometry string "=WxH{+-}X{+-}Y" fed one byte per
// transaction on chars; a zero byte ends the string and yields exactly one
// transaction on results with the found mask (x, y, width, height, x negative,
// y negative) and the four values, or mask 0 and all values 0 on a syntax
// error, trailing junk or an empty string. The parse state updates in the
// cycle a byte is taken, and a terminator's result sits in the output
// register from the next cycle. chars stays ready every cycle except while a
// finished result waits in that register and results is not ready. Digit
// runs saturate at VALUE_MAX; the parser is back at the start of a string
// right after each terminator.
// ----------------------------------------------------------------------------
`default_nettype none
`include "geometry_spec_parser_core_macros.svh"

module geometry_spec_parser_core
  import gsp_pkg::*;
#(
  parameter int unsigned VALUE_MAX = GSP_VALUE_MAX
) (
  input  wire logic    clk,
  input  wire logic    rst,
  gsp_char_if.sink     chars,
  gsp_result_if.source results
);

  localparam int ACC_W  = $clog2(64'(VALUE_MAX) + 64'd1);
  localparam int PROD_W = ACC_W + 4;

  localparam logic [3:0] PH_START     = 4'd0;
  localparam logic [3:0] PH_AFTER_EQ  = 4'd1;
  localparam logic [3:0] PH_NUM_START = 4'd2;
  localparam logic [3:0] PH_NUM_BODY  = 4'd6;
  localparam logic [3:0] PH_ERROR     = 4'd10;

  localparam logic [1:0] TGT_W = 2'd0;
  localparam logic [1:0] TGT_H = 2'd1;
  localparam logic [1:0] TGT_X = 2'd2;
  localparam logic [1:0] TGT_Y = 2'd3;

  // parse state
  logic [3:0]          phase, phase_next;
  logic [ACC_W-1:0]    acc, acc_next;
  logic                neg, neg_next;
  logic                adv, adv_next;
  logic [MASK_W-1:0]   mask_bits, mask_bits_next;
  logic [WIDTH_W-1:0]  width_held, width_held_next;
  logic [HEIGHT_W-1:0] height_held, height_held_next;
  logic [OFFS_W-1:0]   x_held, x_held_next;
  logic [OFFS_W-1:0]   y_held, y_held_next;

  // result register
  logic                res_valid;
  logic [MASK_W-1:0]   res_mask;
  logic [OFFS_W-1:0]   res_x;
  logic [OFFS_W-1:0]   res_y;
  logic [WIDTH_W-1:0]  res_w;
  logic [HEIGHT_W-1:0] res_h;

  logic              in_fire;
  logic [CHAR_W-1:0] c;
  logic              is_sign, is_digit;
  logic [3:0]        digit;

  logic              go_eq, body_run, dec_run, emit, emit_ok;
  logic [1:0]        body_tgt, dec_lvl;
  logic [ACC_W-1:0]  acc_in;
  logic              neg_in, adv_in;
  logic [PROD_W-1:0] prod;
  logic [ACC_W+16:0] acc_ext;
  logic [16:0]       sval;

  assign chars.ready = !res_valid || results.ready;
  assign in_fire     = chars.valid && chars.ready;
  assign c           = chars.char_code;
  assign is_sign     = (c == CH_PLUS) || (c == CH_MINUS);
  assign is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit       = 4'(c - CH_ZERO);

  assign prod    = ({4'b0, acc_in} << 3) + ({4'b0, acc_in} << 1) + PROD_W'(digit);
  assign acc_ext = {17'b0, acc_in};
  assign sval    = neg_in ? (17'd0 - acc_ext[16:0]) : acc_ext[16:0];

  always_comb begin
    phase_next       = phase;
    acc_next         = acc;
    neg_next         = neg;
    adv_next         = adv;
    mask_bits_next   = mask_bits;
    width_held_next  = width_held;
    height_held_next = height_held;
    x_held_next      = x_held;
    y_held_next      = y_held;
    go_eq    = 1'b0;
    body_run = 1'b0;
    dec_run  = 1'b0;
    emit     = 1'b0;
    emit_ok  = 1'b0;
    body_tgt = TGT_W;
    dec_lvl  = TGT_W;
    acc_in   = acc;
    neg_in   = neg;
    adv_in   = adv;

    // phase dispatch
    if (phase == PH_START) begin
      if (c == CH_NUL) begin
        emit = 1'b1;
      end else if (c == CH_EQ) begin
        phase_next = PH_AFTER_EQ;
      end else begin
        go_eq = 1'b1;
      end
    end else if (phase == PH_AFTER_EQ) begin
      go_eq = 1'b1;
    end else if (phase >= PH_NUM_START && phase < PH_NUM_BODY) begin
      body_tgt = 2'(phase - PH_NUM_START);
      if (is_sign) begin
        neg_next   = (c == CH_MINUS);
        adv_next   = 1'b1;
        phase_next = PH_NUM_BODY + {2'b0, body_tgt};
      end else begin
        body_run = 1'b1;
      end
    end else if (phase >= PH_NUM_BODY && phase < PH_ERROR) begin
      body_tgt = 2'(phase - PH_NUM_BODY);
      body_run = 1'b1;
    end else begin
      phase_next = PH_ERROR;
      emit       = (c == CH_NUL);
    end

    // width may not start with a sign or lower-case x
    if (go_eq) begin
      if (is_sign || c == CH_LOWER_X) begin
        dec_run = 1'b1;
      end else begin
        body_run = 1'b1;
        acc_in   = '0;
        neg_in   = 1'b0;
        adv_in   = 1'b0;
        acc_next = '0;
        neg_next = 1'b0;
        adv_next = 1'b0;
      end
    end

    // number body: accumulate, or close the number and decide what follows; a number with no digit or sign is an error
    if (body_run) begin
      if (is_digit) begin
        acc_next   = (prod > PROD_W'(VALUE_MAX)) ? ACC_W'(VALUE_MAX) : ACC_W'(prod);
        adv_next   = 1'b1;
        phase_next = PH_NUM_BODY + {2'b0, body_tgt};
      end else if (!adv_in) begin
        phase_next = PH_ERROR;
        emit       = (c == CH_NUL);
      end else begin
        unique case (body_tgt)
          TGT_W: begin
            width_held_next      = sval[WIDTH_W-1:0];
            mask_bits_next[MB_W] = 1'b1;
          end
          TGT_H: begin
            height_held_next     = sval;
            mask_bits_next[MB_H] = 1'b1;
          end
          TGT_X: begin
            x_held_next          = mask_bits[MB_X_NEG] ? (17'd0 - sval) : sval;
            mask_bits_next[MB_X] = 1'b1;
          end
          TGT_Y: begin
            y_held_next          = mask_bits[MB_Y_NEG] ? (17'd0 - sval) : sval;
            mask_bits_next[MB_Y] = 1'b1;
          end
          default: ;
        endcase
        dec_run = 1'b1;
        dec_lvl = body_tgt;
      end
    end

    if (dec_run) begin
      priority if (dec_lvl == TGT_W && (c == CH_LOWER_X || c == CH_UPPER_X)) begin
        phase_next = PH_NUM_START + {2'b0, TGT_H};
        acc_next   = '0;
        neg_next   = 1'b0;
        adv_next   = 1'b0;
      end else if ((dec_lvl == TGT_W || dec_lvl == TGT_H) && is_sign) begin
        if (c == CH_MINUS) mask_bits_next[MB_X_NEG] = 1'b1;
        phase_next = PH_NUM_START + {2'b0, TGT_X};
        acc_next   = '0;
        neg_next   = 1'b0;
        adv_next   = 1'b0;
      end else if (dec_lvl == TGT_X && is_sign) begin
        if (c == CH_MINUS) mask_bits_next[MB_Y_NEG] = 1'b1;
        phase_next = PH_NUM_START + {2'b0, TGT_Y};
        acc_next   = '0;
        neg_next   = 1'b0;
        adv_next   = 1'b0;
      end else if (c == CH_NUL) begin
        emit    = 1'b1;
        emit_ok = 1'b1;
      end else begin
        phase_next = PH_ERROR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      acc         <= '0;
      neg         <= 1'b0;
      adv         <= 1'b0;
      mask_bits   <= '0;
      width_held  <= '0;
      height_held <= '0;
      x_held      <= '0;
      y_held      <= '0;
    end else if (in_fire) begin
      if (emit) begin
        // terminator: back to the start of a string
        phase       <= PH_START;
        acc         <= '0;
        neg         <= 1'b0;
        adv         <= 1'b0;
        mask_bits   <= '0;
        width_held  <= '0;
        height_held <= '0;
        x_held      <= '0;
        y_held      <= '0;
      end else begin
        phase       <= phase_next;
        acc         <= acc_next;
        neg         <= neg_next;
        adv         <= adv_next;
        mask_bits   <= mask_bits_next;
        width_held  <= width_held_next;
        height_held <= height_held_next;
        x_held      <= x_held_next;
        y_held      <= y_held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_fire && emit) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      res_mask <= emit_ok ? mask_bits_next   : '0;
      res_x    <= emit_ok ? x_held_next      : '0;
      res_y    <= emit_ok ? y_held_next      : '0;
      res_w    <= emit_ok ? width_held_next  : '0;
      res_h    <= emit_ok ? height_held_next : '0;
    end
  end

  assign results.valid        = res_valid;
  assign results.found_mask   = res_mask;
  assign results.x_offset     = res_x;
  assign results.y_offset     = res_y;
  assign results.width_value  = res_w;
  assign results.height_value = res_h;

  `GSP_ASSERT_NOW(a_err_zero, res_valid && res_mask == '0, res_x == '0 && res_y == '0 && res_w == '0 && res_h == '0, "error result carries nonzero values")
  `GSP_ASSERT_NOW(a_width_unfound, res_valid && !res_mask[MB_W], res_w == '0, "width value set without width found")
  `GSP_ASSERT_NEXT(a_term_restart, in_fire && c == CH_NUL, phase == PH_START && mask_bits == '0, "parser not restarted after terminator")
  `GSP_ASSERT_NOW(a_acc_sat, 1'b1, 64'(acc) <= 64'(VALUE_MAX), "accumulator above saturation limit")
  `GSP_ASSERT_NOW(a_stall, res_valid && !results.ready, !chars.ready, "byte taken while result register is blocked")

endmodule

`default_nettype wire

>>> tb/sv/tb_geometry_spec_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_geometry_spec_parser_core
// Feeds geometry strings byte by byte into the parser with random idle and
// stall bursts. A tracker parses the same bytes and queues the geometry it
// expects at every terminator. Each result transaction is checked against it.
// ----------------------------------------------------------------------------

module tb_geometry_spec_parser_core;
  import gsp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int CALM_TAIL   = 150;
  localparam int TARGET_BYTES = 1300;

  typedef enum logic [2:0] {
    PS_START, PS_AFTER_EQ, PS_NUM_START, PS_NUM_BODY, PS_ERROR
  } parse_phase_t;

  typedef enum logic [1:0] {TG_WIDTH, TG_HEIGHT, TG_X, TG_Y} target_t;

  typedef struct packed {
    logic [MASK_W-1:0]   found_mask;
    logic [OFFS_W-1:0]   x_offset;
    logic [OFFS_W-1:0]   y_offset;
    logic [WIDTH_W-1:0]  width_value;
    logic [HEIGHT_W-1:0] height_value;
  } geometry_t;

  class geometry_tracker_t;
    geometry_t pending_geometries[$];
    int errors;
    int checked;
    int found_count;

    parse_phase_t phase;
    target_t target;
    longint unsigned digits_value;
    bit negate_inner;
    bit number_seen;
    logic [MASK_W-1:0] mask;
    longint width_held, height_held, x_held, y_held;

    function new();
      errors = 0;
      checked = 0;
      found_count = 0;
      restart();
    endfunction

    function void restart();
      phase = PS_START;
      target = TG_WIDTH;
      digits_value = 0;
      negate_inner = 0;
      number_seen = 0;
      mask = '0;
      width_held = 0;
      height_held = 0;
      x_held = 0;
      y_held = 0;
    endfunction

    function void end_string(bit ok);
      geometry_t g;
      g = '0;
      if (ok) begin
        g.found_mask   = mask;
        g.x_offset     = x_held[OFFS_W-1:0];
        g.y_offset     = y_held[OFFS_W-1:0];
        g.width_value  = width_held[WIDTH_W-1:0];
        g.height_value = height_held[HEIGHT_W-1:0];
      end
      pending_geometries.push_back(g);
      restart();
    endfunction

    function void begin_number(target_t t);
      phase = PS_NUM_START;
      target = t;
      digits_value = 0;
      negate_inner = 0;
      number_seen = 0;
    endfunction

    function void store_number();
      longint v;
      v = negate_inner ? -longint'(digits_value) : longint'(digits_value);
      case (target)
        TG_WIDTH: begin
          width_held = v;
          mask[MB_W] = 1'b1;
        end
        TG_HEIGHT: begin
          height_held = v;
          mask[MB_H] = 1'b1;
        end
        TG_X: begin
          x_held = mask[MB_X_NEG] ? -v : v;
          mask[MB_X] = 1'b1;
        end
        default: begin
          y_held = mask[MB_Y_NEG] ? -v : v;
          mask[MB_Y] = 1'b1;
        end
      endcase
    endfunction

    // what may follow a finished part, by the part just finished
    function void follow_part(target_t level, logic [CHAR_W-1:0] c);
      bit is_sign;
      is_sign = (c == CH_PLUS) || (c == CH_MINUS);
      if (level == TG_WIDTH && (c == CH_LOWER_X || c == CH_UPPER_X)) begin
        begin_number(TG_HEIGHT);
        return;
      end
      if ((level == TG_WIDTH || level == TG_HEIGHT) && is_sign) begin
        if (c == CH_MINUS) mask[MB_X_NEG] = 1'b1;
        begin_number(TG_X);
        return;
      end
      if (level == TG_X && is_sign) begin
        if (c == CH_MINUS) mask[MB_Y_NEG] = 1'b1;
        begin_number(TG_Y);
        return;
      end
      if (c == CH_NUL) begin
        end_string(1'b1);
        return;
      end
      phase = PS_ERROR;
    endfunction

    function void number_char(logic [CHAR_W-1:0] c);
      longint unsigned n;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        n = digits_value * 10 + longint'(c - CH_ZERO);
        digits_value = (n > GSP_VALUE_MAX) ? GSP_VALUE_MAX : n;
        number_seen = 1'b1;
        phase = PS_NUM_BODY;
        return;
      end
      if (!number_seen) begin
        if (c == CH_NUL) end_string(1'b0);
        else phase = PS_ERROR;
        return;
      end
      store_number();
      follow_part(target, c);
    endfunction

    function void note_char(logic [CHAR_W-1:0] c);
      if (phase == PS_START) begin
        if (c == CH_NUL) begin
          end_string(1'b0);
          return;
        end
        phase = PS_AFTER_EQ;
        if (c == CH_EQ) return;
      end
      case (phase)
        PS_AFTER_EQ: begin
          if (c == CH_PLUS || c == CH_MINUS || c == CH_LOWER_X) begin
            follow_part(TG_WIDTH, c);
          end else begin
            begin_number(TG_WIDTH);
            number_char(c);
          end
        end
        PS_NUM_START: begin
          // inner sign counts as a number even with no digits
          if (c == CH_PLUS || c == CH_MINUS) begin
            negate_inner = (c == CH_MINUS);
            number_seen = 1'b1;
            phase = PS_NUM_BODY;
          end else begin
            number_char(c);
          end
        end
        PS_NUM_BODY: number_char(c);
        default: begin
          phase = PS_ERROR;
          if (c == CH_NUL) end_string(1'b0);
        end
      endcase
    endfunction

    function void check_geometry(geometry_t got);
      geometry_t exp_g;
      if (pending_geometries.size() == 0) begin
        $error("result transaction with no string pending");
        errors++;
        return;
      end
      exp_g = pending_geometries.pop_front();
      checked++;
      if (exp_g.found_mask != 0) found_count++;
      if (got.found_mask !== exp_g.found_mask) begin
        $error("found_mask expected %h actual %h", exp_g.found_mask, got.found_mask);
        errors++;
      end
      if (got.x_offset !== exp_g.x_offset) begin
        $error("x_offset expected %h actual %h", exp_g.x_offset, got.x_offset);
        errors++;
      end
      if (got.y_offset !== exp_g.y_offset) begin
        $error("y_offset expected %h actual %h", exp_g.y_offset, got.y_offset);
        errors++;
      end
      if (got.width_value !== exp_g.width_value) begin
        $error("width_value expected %h actual %h", exp_g.width_value, got.width_value);
        errors++;
      end
      if (got.height_value !== exp_g.height_value) begin
        $error("height_value expected %h actual %h", exp_g.height_value, got.height_value);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit calm = 1'b0;
  logic [CHAR_W-1:0] char_stream[$];
  geometry_t observed;
  geometry_tracker_t tracker = new();

  gsp_char_if   chars();
  gsp_result_if results();

  geometry_spec_parser_core dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars),
    .results (results)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) char_stream.push_back(s[i]);
  endfunction

  function automatic void push_sign(ref logic [CHAR_W-1:0] str[$]);
    str.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
  endfunction

  function automatic void push_number(ref logic [CHAR_W-1:0] str[$], input bit may_sign);
    bit signed_num;
    int n;
    signed_num = may_sign && ($urandom_range(0, 3) == 0);
    if (signed_num) push_sign(str);
    if (signed_num && $urandom_range(0, 2) == 0) return;
    if ($urandom_range(0, 19) == 0) return;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
    repeat (n) str.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  // mostly well-formed strings, some corrupted by one byte, some pure noise
  function automatic void add_geometry();
    logic [CHAR_W-1:0] str[$];
    int kind;
    int pos;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      repeat ($urandom_range(0, 6)) str.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 1)) str.push_back(CH_EQ);
      if ($urandom_range(0, 3) != 0) push_number(str, 1'b0);
      if ($urandom_range(0, 2) != 0) begin
        str.push_back(($urandom_range(0, 7) == 0) ? CH_UPPER_X : CH_LOWER_X);
        push_number(str, 1'b1);
      end
      if ($urandom_range(0, 2) != 0) begin
        push_sign(str);
        push_number(str, 1'b1);
        if ($urandom_range(0, 2) != 0) begin
          push_sign(str);
          push_number(str, 1'b1);
        end
      end
      if (kind < 5 && str.size() > 0) begin
        pos = $urandom_range(0, str.size() - 1);
        if ($urandom_range(0, 1)) str[pos] = 8'($urandom_range(1, 255));
        else str.insert(pos, 8'($urandom_range(1, 255)));
      end
    end
    foreach (str[i]) char_stream.push_back(str[i]);
    char_stream.push_back(CH_NUL);
  endfunction

  task automatic send_chars();
    int idx;
    idx = 0;
    while (idx < char_stream.size()) begin
      if (idx >= char_stream.size() - CALM_TAIL) calm = 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) begin
        chars.valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      chars.valid <= 1'b1;
      chars.char_code <= char_stream[idx];
      do @(posedge clk); while (!chars.ready);
      idx++;
    end
    chars.valid <= 1'b0;
  endtask

  task automatic pace_results();
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        results.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      results.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  // inputs are noted before results so a same-edge result would still find its string
  always @(posedge clk) begin
    if (!rst && chars.valid && chars.ready) tracker.note_char(chars.char_code);
    if (!rst && results.valid && results.ready) begin
      observed.found_mask   = results.found_mask;
      observed.x_offset     = results.x_offset;
      observed.y_offset     = results.y_offset;
      observed.width_value  = results.width_value;
      observed.height_value = results.height_value;
      tracker.check_geometry(observed);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst && ((chars.valid && chars.ready) || (results.valid && results.ready)))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    chars.valid <= 1'b0;
    chars.char_code <= CH_NUL;
    results.ready <= 1'b0;

    // empty string, saturation with inner and outer signs, upper-case x as width,
    // trailing junk with an all-ones byte, missing number after x
    char_stream.push_back(CH_NUL);
    add_text("=99999x-8-+3--");
    char_stream.push_back(CH_NUL);
    add_text("X");
    char_stream.push_back(CH_NUL);
    add_text("-5x");
    char_stream.push_back(8'hFF);
    char_stream.push_back(CH_NUL);
    add_text("x");
    char_stream.push_back(CH_NUL);
    while (char_stream.size() < TARGET_BYTES) add_geometry();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    fork
      pace_results();
    join_none
    send_chars();

    while (tracker.pending_geometries.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (tracker.pending_geometries.size() != 0) begin
      $error("%0d strings ended without a result transaction",
             tracker.pending_geometries.size());
      tracker.errors++;
    end

    $display("fed %0d string bytes, checked %0d geometry results (%0d with parts found)",
             char_stream.size(), tracker.checked, tracker.found_count);
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
